[src/rit_pkg.sv]
// Shared types, constants and helper functions for the radix integer-to-ASCII block.
package rit_pkg;

    // Number format
    localparam int VALUE_WIDTH = 64;
    localparam int MAX_RADIX   = 16;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int ALPHA_W     = 64;

    // Divider: bits of the dividend retired per cycle
    localparam int STEP_BITS  = 8;
    localparam int STEP_COUNT = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int STEP_W     = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
    localparam int WORK_W     = STEP_COUNT * STEP_BITS;

    // Digit store
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);

    // Configuration port
    localparam int CFG_INDEX_W = 2;

    localparam logic [RADIX_W-1:0] RESET_RADIX      = RADIX_W'(10);
    localparam logic [ALPHA_W-1:0] RESET_ALPHA_LOW  = 64'h3736353433323130;
    localparam logic [ALPHA_W-1:0] RESET_ALPHA_HIGH = 64'h6665646362613938;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RADIX      = 2'd0,
        CFG_ALPHA_LOW  = 2'd1,
        CFG_ALPHA_HIGH = 2'd2
    } cfg_index_t;

    typedef enum logic [0:0] {
        OP_UNSIGNED = 1'b0,
        OP_SIGNED   = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_EMIT_RD,
        BK_EMIT_LOAD
    } bk_state_t;

    typedef struct packed {
        logic [63:0] value;
        logic        opcode;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              minus_before;
        logic              last;
    } out_word_t;

    // Classified job handed from front to back
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] magnitude;
        logic                   negative;
    } job_t;

    // Clamp the radix register into 2..MAX_RADIX
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_W'(2))
            res = RADIX_W'(2);
        else if (r > RADIX_W'(MAX_RADIX))
            res = RADIX_W'(MAX_RADIX);
        return res;
    endfunction

    // Map a digit value through the two alphabet registers
    function automatic logic [CHAR_W-1:0] digit_to_char(
        input logic [DIGIT_W-1:0] d,
        input logic [ALPHA_W-1:0] lo,
        input logic [ALPHA_W-1:0] hi
    );
        logic [CHAR_W-1:0] c;
        if (d[DIGIT_W-1] == 1'b0)
            c = lo[{d[DIGIT_W-2:0], 3'b000} +: CHAR_W];
        else
            c = hi[{d[DIGIT_W-2:0], 3'b000} +: CHAR_W];
        return c;
    endfunction

endpackage

[src/rit_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rit_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/rit_front.sv]
// Front end: accepts input words and classifies them into sign and magnitude.
module rit_front
    import rit_pkg::*;
(
    input  logic     in_valid,
    input  in_word_t in_word,
    input  logic     queue_full,
    output logic     in_stall,
    output logic     push,
    output job_t     job
);

    logic [VALUE_WIDTH-1:0] raw;
    logic                   negative;

    // Take the low bits and test the sign under a signed reading
    assign raw      = in_word.value[VALUE_WIDTH-1:0];
    assign negative = (in_word.opcode == OP_SIGNED) && raw[VALUE_WIDTH-1];

    // Negate modulo 2^VALUE_WIDTH; the most negative value maps to itself
    assign job.magnitude = negative ? (~raw + VALUE_WIDTH'(1)) : raw;
    assign job.negative  = negative;

    // Hold off the source while the queue is full
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

endmodule

[src/rit_queue.sv]
// Two-entry job queue between the front end and the back end.
module rit_queue
    import rit_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg,   fill_next;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
            fill_next = fill_reg + 2'd1;
        else if (pop && !push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign full       = (fill_reg == 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_job   = slot_reg[rd_ptr_reg];

endmodule

[src/rit_back.sv]
// Back end: divides out the digits, stores them, and emits characters most significant first.
module rit_back
    import rit_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  job_t               job,
    output logic               job_pop,
    input  logic [RADIX_W-1:0] radix_eff,
    input  logic [ALPHA_W-1:0] alpha_low,
    input  logic [ALPHA_W-1:0] alpha_high,
    output logic               out_valid,
    input  logic               out_stall,
    output out_word_t          out_word
);

    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(STEP_COUNT - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(STORE_DEPTH);

    bk_state_t            state_reg, state_next;
    logic [WORK_W-1:0]    work_reg,  work_next;
    logic [DIGIT_W-1:0]   rem_reg,   rem_next;
    logic [STEP_W-1:0]    step_reg,  step_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   idx_reg,   idx_next;
    logic                 neg_reg,   neg_next;
    logic                 out_valid_reg, out_valid_next;
    out_word_t            out_word_reg,  out_word_next;

    logic [WORK_W-1:0]    work_after;
    logic [DIGIT_W-1:0]   rem_after;
    logic                 digit_done;
    logic                 digits_over;
    logic [COUNT_W-1:0]   count_plus;
    logic                 out_free;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [DIGIT_W-1:0]   ram_rdata;

    // Restoring division over STEP_BITS dividend bits
    always_comb
    begin
        logic [DIGIT_W-1:0]   r_v;
        logic [DIGIT_W:0]     t_v;
        logic [STEP_BITS-1:0] q_v;
        r_v = rem_reg;
        q_v = '0;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            t_v = {r_v, work_reg[WORK_W-1-k]};
            if (t_v >= (DIGIT_W+1)'(radix_eff))
            begin
                q_v[STEP_BITS-1-k] = 1'b1;
                r_v = DIGIT_W'(t_v - (DIGIT_W+1)'(radix_eff));
            end
            else
            begin
                r_v = t_v[DIGIT_W-1:0];
            end
        end
        rem_after  = r_v;
        work_after = (work_reg << STEP_BITS) | WORK_W'(q_v);
    end

    assign count_plus  = count_reg + COUNT_W'(1);
    assign digit_done  = (step_reg == STEP_LAST);
    assign digits_over = (work_after == '0) || (count_plus == COUNT_MAX);
    assign out_free    = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                    state_next = BK_DIVIDE;
            end
            BK_DIVIDE:
            begin
                if (digit_done && digits_over)
                    state_next = BK_EMIT_RD;
            end
            BK_EMIT_RD:
            begin
                if (out_free)
                    state_next = BK_EMIT_LOAD;
            end
            BK_EMIT_LOAD:
            begin
                if (idx_reg == COUNT_W'(1))
                    state_next = BK_IDLE;
                else
                    state_next = BK_EMIT_RD;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        work_next      = work_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg;
        job_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[ADDR_W-1:0];

        // Drop the output word once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    work_next  = WORK_W'(job.magnitude);
                    neg_next   = job.negative;
                    rem_next   = '0;
                    step_next  = '0;
                    count_next = '0;
                end
            end
            BK_DIVIDE:
            begin
                work_next = work_after;
                if (digit_done)
                begin
                    ram_we     = 1'b1;
                    count_next = count_plus;
                    idx_next   = count_plus;
                    rem_next   = '0;
                    step_next  = '0;
                end
                else
                begin
                    rem_next  = rem_after;
                    step_next = step_reg + STEP_W'(1);
                end
            end
            BK_EMIT_RD:
            begin
            end
            BK_EMIT_LOAD:
            begin
                out_word_next.digit_char   = digit_to_char(ram_rdata, alpha_low, alpha_high);
                out_word_next.minus_before = neg_reg && (idx_reg == count_reg);
                out_word_next.last         = (idx_reg == COUNT_W'(1));
                out_valid_next             = 1'b1;
                idx_next                   = idx_reg - COUNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Read the stored digit for the current emit position
    assign ram_raddr = ADDR_W'(idx_reg - COUNT_W'(1));

    rit_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rem_after),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        rem_reg      <= rem_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

[src/radix_integer_to_ascii.sv]
// Top level of the radix integer-to-ASCII converter.
// Converts a 64-bit value (unsigned or two's complement signed, by opcode) into
// digit characters in the configured radix (2 to 16, clamped), most significant
// first, one output word per digit, with last on the final digit and
// minus_before on the first digit of a negative number. The divider retires 8
// dividend bits per cycle to divide out each digit, and the stored digits are
// then read back from the digit store and presented while the output is free.
// A two-entry queue lets up to two further input words be accepted while one
// is converted. Configuration writes are always ready and must be issued only
// while idle.
module radix_integer_to_ascii
    import rit_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_word_t               in_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_word_t              out_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    logic [RADIX_W-1:0] radix_reg,      radix_next;
    logic [ALPHA_W-1:0] alpha_low_reg,  alpha_low_next;
    logic [ALPHA_W-1:0] alpha_high_reg, alpha_high_next;

    logic queue_full;
    logic push;
    job_t front_job;
    logic head_valid;
    job_t head_job;
    logic pop;

    // Decode configuration writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        radix_next      = radix_reg;
        alpha_low_next  = alpha_low_reg;
        alpha_high_next = alpha_high_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RADIX:      radix_next      = cfg_data[RADIX_W-1:0];
                CFG_ALPHA_LOW:  alpha_low_next  = cfg_data;
                CFG_ALPHA_HIGH: alpha_high_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= RESET_RADIX;
            alpha_low_reg  <= RESET_ALPHA_LOW;
            alpha_high_reg <= RESET_ALPHA_HIGH;
        end
        else
        begin
            radix_reg      <= radix_next;
            alpha_low_reg  <= alpha_low_next;
            alpha_high_reg <= alpha_high_next;
        end
    end

    rit_front u_front (
        .in_valid   (in_valid),
        .in_word    (in_word),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .job        (front_job)
    );

    rit_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (front_job),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    rit_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (head_valid),
        .job        (head_job),
        .job_pop    (pop),
        .radix_eff  (clamp_radix(radix_reg)),
        .alpha_low  (alpha_low_reg),
        .alpha_high (alpha_high_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

endmodule

[src/rit_checker.sv]
// Port-level checker for the radix integer-to-ASCII converter, bound to the top level.
module rit_checker
    import rit_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_stall,
    input out_word_t              out_word,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);

    // A stalled output word stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // A stalled output word holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_word))
        else $error("output word changed while stalled");

    // The minus flag never follows a digit that was not last
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_word.last |=> !(out_valid && out_word.minus_before))
        else $error("minus flag inside a number");

    // Two digits are never presented on consecutive taken cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("output word reloaded without a store read");

    // Configuration port never back-pressures
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind radix_integer_to_ascii rit_checker u_rit_checker (.*);

[bench/radix_integer_to_ascii_tb.sv]
// Testbench for the radix integer-to-ASCII converter: directed and random numbers checked digit by digit.
`timescale 1ns / 100ps

module radix_integer_to_ascii_tb;
    import rit_pkg::*;

    // Register index that maps to no register
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 700;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_word_t               in_word   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_word_t              out_word;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [63:0]            cfg_data  = '0;

    // Shadow copy of the configuration registers
    logic [RADIX_W-1:0] radix_reg = RESET_RADIX;
    logic [ALPHA_W-1:0] alpha_lo  = RESET_ALPHA_LOW;
    logic [ALPHA_W-1:0] alpha_hi  = RESET_ALPHA_HIGH;

    out_word_t digits_due[$];
    out_word_t due_word;
    int        mismatch_count = 0;
    bit        idle_on        = 1'b1;
    logic      hold_req       = 1'b0;
    logic      hold_ack       = 1'b0;
    int        hold_left      = 0;
    int        burst_left     = 0;

    radix_integer_to_ascii uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        #60_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Work out the digit words of one number under the current configuration
    function automatic void predict_digits(input logic [63:0] v, input opcode_t op);
        logic [63:0]        mag;
        logic [63:0]        base;
        logic [DIGIT_W-1:0] rems[STORE_DEPTH];
        logic [DIGIT_W-1:0] d;
        logic [RADIX_W-1:0] r;
        logic               neg;
        int                 n;
        out_word_t          w;
        r = radix_reg;
        if (r < 2)
            r = RADIX_W'(2);
        else if (r > MAX_RADIX)
            r = RADIX_W'(MAX_RADIX);
        base = 64'(r);
        neg = (op == OP_SIGNED) && v[63];
        mag = neg ? -v : v;
        n = 0;
        do
        begin
            rems[n] = DIGIT_W'(mag % base);
            mag = mag / base;
            n++;
        end
        while (mag != 0);
        // most significant digit sits at the top of the remainder list
        for (int i = n - 1; i >= 0; i--)
        begin
            d = rems[i];
            w.digit_char   = d[3] ? CHAR_W'(alpha_hi >> (8 * d[2:0]))
                                  : CHAR_W'(alpha_lo >> (8 * d[2:0]));
            w.minus_before = neg && (i == n - 1);
            w.last         = (i == 0);
            digits_due.push_back(w);
        end
    endfunction

    // Pick a number with a bias toward the edges of the range
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(0, 6))
            0: v = 64'($urandom_range(0, 1000));
            1: v = $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
            2: v = {32'hFFFF_FFFF, $urandom};
            3: v = 64'd1 << $urandom_range(0, 63);
            4: v = {32'h0, $urandom};
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Offer one number and hold it until the block takes it
    task automatic send_number(input logic [63:0] v, input opcode_t op);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= in_word_t'{value: v, opcode: op};
        do @(posedge clk); while (in_stall);
        predict_digits(v, op);
    endtask

    // Drop valid after the last word of a test
    task automatic stop_numbers();
        in_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_number(pick_value(), opcode_t'($urandom_range(0, 1)));
    endtask

    // Write one register once every pending digit has come out
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        do @(posedge clk); while (digits_due.size() != 0);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RADIX:      radix_reg = data[RADIX_W-1:0];
            CFG_ALPHA_LOW:  alpha_lo  = data;
            CFG_ALPHA_HIGH: alpha_hi  = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [RADIX_W-1:0] r, input logic [63:0] lo,
                              input logic [63:0] hi);
        write_reg(CFG_RADIX, 64'(r));
        write_reg(CFG_ALPHA_LOW, lo);
        write_reg(CFG_ALPHA_HIGH, hi);
    endtask

    // Reset configuration: decimal with the stock alphabet
    task automatic test_reset_config();
        send_number(64'd0, OP_UNSIGNED);
        send_number(64'd0, OP_SIGNED);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, OP_UNSIGNED);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, OP_SIGNED);
        send_number(64'h8000_0000_0000_0000, OP_SIGNED);
        send_number(64'h7FFF_FFFF_FFFF_FFFF, OP_SIGNED);
        send_number(64'd1, OP_UNSIGNED);
        send_number(64'd9, OP_SIGNED);
        send_number(64'd10, OP_UNSIGNED);
        send_number(64'd123456789, OP_SIGNED);
        stop_numbers();
    endtask

    // Smallest and largest radix, and register values that clamp
    task automatic test_radix_limits();
        set_config(5'd2, RESET_ALPHA_LOW, RESET_ALPHA_HIGH);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, OP_UNSIGNED);
        send_number(64'h8000_0000_0000_0000, OP_SIGNED);
        send_number(64'd1, OP_SIGNED);
        stop_numbers();
        write_reg(CFG_RADIX, 64'd16);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, OP_UNSIGNED);
        send_number(64'hFEDC_BA98_7654_3210, OP_UNSIGNED);
        stop_numbers();
        write_reg(CFG_RADIX, 64'd0);
        send_number(64'd5, OP_UNSIGNED);
        stop_numbers();
        write_reg(CFG_RADIX, 64'd1);
        send_number(64'd6, OP_SIGNED);
        stop_numbers();
        write_reg(CFG_RADIX, 64'd17);
        send_number(64'd255, OP_UNSIGNED);
        stop_numbers();
        write_reg(CFG_RADIX, 64'd31);
        send_number(64'h1234, OP_UNSIGNED);
        stop_numbers();
    endtask

    // Custom alphabets, and a write to an unmapped index that must be ignored
    task automatic test_alphabet();
        set_config(5'd16, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(64'h0123_4567_89AB_CDEF, OP_UNSIGNED);
        stop_numbers();
        set_config(5'd16, 64'h4847_4645_4443_4241, 64'h504F_4E4D_4C4B_4A49);
        send_number(64'hF0E1_D2C3_B4A5_9687, OP_SIGNED);
        stop_numbers();
        write_reg(CFG_SPARE, 64'h0);
        send_number(64'h0123_4567_89AB_CDEF, OP_SIGNED);
        stop_numbers();
    endtask

    // Hold the result side off long enough that the input side backs up
    task automatic test_backpressure();
        set_config(RESET_RADIX, RESET_ALPHA_LOW, RESET_ALPHA_HIGH);
        hold_req <= ~hold_req;
        for (int i = 0; i < 12; i++)
            send_number(64'($urandom_range(0, 99)), opcode_t'($urandom_range(0, 1)));
        stop_numbers();
    endtask

    // Random configurations, each followed by a run of random numbers
    task automatic test_random_phases();
        for (int p = 0; p < 8; p++)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
                set_config(RADIX_W'($urandom_range(0, 31)), RESET_ALPHA_LOW, RESET_ALPHA_HIGH);
            else
                set_config(RADIX_W'($urandom_range(0, 31)), {$urandom, $urandom},
                           {$urandom, $urandom});
            send_random(50);
            stop_numbers();
        end
    endtask

    // Full-rate tail with no idling on either side
    task automatic test_full_rate();
        idle_on = 1'b0;
        set_config(5'd16, {$urandom, $urandom}, {$urandom, $urandom});
        send_random(40);
        stop_numbers();
    endtask

    // Drive the result stall: long hold-off on request, otherwise random bursts
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_left = HOLD_CYCLES;
            hold_ack  = hold_req;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (burst_left > 0)
        begin
            out_stall <= 1'b1;
            burst_left--;
        end
        else if (idle_on && $urandom_range(0, 6) == 0)
        begin
            out_stall <= 1'b1;
            burst_left = $urandom_range(0, 4);
        end
        else
            out_stall <= 1'b0;
    end

    // Compare every accepted digit word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (digits_due.size() == 0)
            begin
                $error("unexpected digit word %h", out_word);
                mismatch_count++;
            end
            else
            begin
                due_word = digits_due.pop_front();
                if (out_word.digit_char !== due_word.digit_char)
                begin
                    $error("digit_char expected %h got %h", due_word.digit_char,
                           out_word.digit_char);
                    mismatch_count++;
                end
                if (out_word.minus_before !== due_word.minus_before)
                begin
                    $error("minus_before expected %b got %b", due_word.minus_before,
                           out_word.minus_before);
                    mismatch_count++;
                end
                if (out_word.last !== due_word.last)
                begin
                    $error("last expected %b got %b", due_word.last, out_word.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_radix_limits();
        test_alphabet();
        test_backpressure();
        test_random_phases();
        test_full_rate();
        // drain, then allow for a slow last conversion
        while (digits_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && digits_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
